// ----- hdl/min_max_normalize_to_u8_macros.svh -----
// Assertion macros used by the min-max normalizer top level.
`ifndef MIN_MAX_NORMALIZE_TO_U8_MACROS_SVH
`define MIN_MAX_NORMALIZE_TO_U8_MACROS_SVH

// Overlapping implication, checked on every clock edge out of reset.
`define MMN_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define MMN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mmn_pkg.sv -----
// Types and constants for the min-max normalizer.
`timescale 1ns / 1ps
package mmn_pkg;

  localparam int unsigned IN_PIX_BITS = 16;
  localparam int unsigned QUO_BITS    = 8;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [QUO_BITS-1:0] OUT_SCALE = 8'hFF;
  localparam logic [QUO_BITS-1:0] OUT_ZERO  = 8'h00;

  typedef struct packed {
    logic                   op;
    logic [IN_PIX_BITS-1:0] pixel;
    logic                   last;
  } in_word_t;

  typedef struct packed {
    logic [QUO_BITS-1:0] out_value;
    logic                out_last;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic bypass;
  } ctl_t;

endpackage

// ----- hdl/mmn_stats.sv -----
// Running minimum and maximum of the measure pass, and the latched min and range.
`timescale 1ns / 1ps
module mmn_stats #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  meas_i,
  input  logic [PIXEL_BITS-1:0] pixel_i,
  input  logic                  last_i,
  output logic [PIXEL_BITS-1:0] held_min_o,
  output logic [PIXEL_BITS-1:0] held_range_o
);

  logic [PIXEL_BITS-1:0] run_min_q, run_max_q;
  logic [PIXEL_BITS-1:0] held_min_q, held_range_q;
  logic [PIXEL_BITS-1:0] mn, mx;

  assign mn = (pixel_i < run_min_q) ? pixel_i : run_min_q;
  assign mx = (pixel_i > run_max_q) ? pixel_i : run_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q    <= '1;
      run_max_q    <= '0;
      held_min_q   <= '0;
      held_range_q <= '0;
    end else if (meas_i) begin
      if (last_i) begin
        held_min_q   <= mn;
        held_range_q <= mx - mn;
        run_min_q    <= '1;
        run_max_q    <= '0;
      end else begin
        run_min_q <= mn;
        run_max_q <= mx;
      end
    end
  end

  assign held_min_o   = held_min_q;
  assign held_range_o = held_range_q;

endmodule

// ----- hdl/mmn_cell.sv -----
// One restoring-division cell: produces one quotient bit per word, or passes the quotient on a bypass word.
`timescale 1ns / 1ps
module mmn_cell #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  mmn_pkg::ctl_t                  ctl_i,
  input  logic [PIXEL_BITS-1:0]          rem_i,
  input  logic [PIXEL_BITS-1:0]          div_i,
  input  logic [mmn_pkg::QUO_BITS-1:0]   num_i,
  input  logic [mmn_pkg::QUO_BITS-1:0]   quo_i,
  output mmn_pkg::ctl_t                  ctl_o,
  output logic [PIXEL_BITS-1:0]          rem_o,
  output logic [PIXEL_BITS-1:0]          div_o,
  output logic [mmn_pkg::QUO_BITS-1:0]   num_o,
  output logic [mmn_pkg::QUO_BITS-1:0]   quo_o
);

  localparam int unsigned QB = mmn_pkg::QUO_BITS;

  mmn_pkg::ctl_t          ctl_q;
  logic [PIXEL_BITS-1:0]  rem_q, rem_d, div_q;
  logic [QB-1:0]          num_q, num_d, quo_q, quo_d;
  logic [PIXEL_BITS:0]    trial, sub;
  logic                   ge;

  assign trial = {rem_i, num_i[QB-1]};
  assign sub   = trial - {1'b0, div_i};
  assign ge    = (trial >= {1'b0, div_i});
  assign rem_d = ge ? sub[PIXEL_BITS-1:0] : trial[PIXEL_BITS-1:0];
  assign num_d = {num_i[QB-2:0], 1'b0};
  assign quo_d = ctl_i.bypass ? quo_i : {quo_i[QB-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      div_q <= div_i;
      num_q <= num_d;
      quo_q <= quo_d;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign div_o = div_q;
  assign num_o = num_q;
  assign quo_o = quo_q;

endmodule

// ----- hdl/min_max_normalize_to_u8.sv -----
// Top level of the two-pass min-max stretch from wide pixels to 8 bits.
// Input channel: in_valid_i / in_stall_o carry one in_word_t per word.
//   op = measure folds the pixel into a running minimum and maximum; on a
//   measure word with last set, the minimum and range are latched and the
//   running values restart. Measure words give no result.
//   op = convert gives one out_word_t: floor(255*(pixel-min)/range),
//   clamped to 0 or 255 outside the range, or the pixel's low byte when the
//   latched range is zero. out_last copies the input last flag.
// Pipeline: an accepted convert word moves from the prepare stage (loaded at
//   the accepting edge) through eight cells and one out reg to out_valid_o.
// Throughput: one word per cycle while not stalled, measure and convert alike;
//   the eight-cell division chain advances one stage per cycle unless stalled.
// Stall: while an output word waits under out_stall_i, the whole chain holds
//   and in_stall_o is high. Results leave in the order their words came in.
// Reset: clears all valid flags, sets the running minimum to all ones, the
//   running maximum, latched minimum and latched range to zero.
`timescale 1ns / 1ps
module min_max_normalize_to_u8 #(
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mmn_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mmn_pkg::out_word_t out_word_o
);

  `include "min_max_normalize_to_u8_macros.svh"

  localparam int unsigned QB    = mmn_pkg::QUO_BITS;
  localparam int unsigned CELLS = mmn_pkg::QUO_BITS;

  logic                   en, acc, meas, conv;
  logic [PIXEL_BITS-1:0]  pix, held_min, held_range, diff;
  logic [PIXEL_BITS+QB-1:0] num_full;
  logic                   below, zero_rng, over;
  mmn_pkg::ctl_t          ctl_f_d;
  logic [QB-1:0]          quo_f_d;

  mmn_pkg::ctl_t          ctl_c [0:CELLS];
  logic [PIXEL_BITS-1:0]  rem_c [0:CELLS];
  logic [PIXEL_BITS-1:0]  div_c [0:CELLS];
  logic [QB-1:0]          num_c [0:CELLS];
  logic [QB-1:0]          quo_c [0:CELLS];

  logic                   out_valid_q;
  mmn_pkg::out_word_t     out_word_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;
  assign meas       = acc && (in_word_i.op == mmn_pkg::OP_MEASURE);
  assign conv       = acc && (in_word_i.op == mmn_pkg::OP_CONVERT);
  assign pix        = in_word_i.pixel[PIXEL_BITS-1:0];

  mmn_stats #(.PIXEL_BITS(PIXEL_BITS)) u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .meas_i       (meas),
    .pixel_i      (pix),
    .last_i       (in_word_i.last),
    .held_min_o   (held_min),
    .held_range_o (held_range)
  );

  assign zero_rng = (held_range == '0);
  assign below    = (pix < held_min);
  assign diff     = pix - held_min;
  assign over     = (diff >= held_range);
  assign num_full = {diff, {QB{1'b0}}} - {{QB{1'b0}}, diff};

  always_comb begin
    ctl_f_d.valid  = conv;
    ctl_f_d.last   = in_word_i.last;
    ctl_f_d.bypass = zero_rng || below || over;
    priority if (zero_rng) begin
      quo_f_d = in_word_i.pixel[QB-1:0];
    end else if (below) begin
      quo_f_d = mmn_pkg::OUT_ZERO;
    end else if (over) begin
      quo_f_d = mmn_pkg::OUT_SCALE;
    end else begin
      quo_f_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c[0] <= '0;
    end else if (en) begin
      ctl_c[0] <= ctl_f_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_c[0] <= num_full[PIXEL_BITS+QB-1:QB];
      num_c[0] <= num_full[QB-1:0];
      div_c[0] <= held_range;
      quo_c[0] <= quo_f_d;
    end
  end

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    mmn_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_c[g]),
      .rem_i  (rem_c[g]),
      .div_i  (div_c[g]),
      .num_i  (num_c[g]),
      .quo_i  (quo_c[g]),
      .ctl_o  (ctl_c[g+1]),
      .rem_o  (rem_c[g+1]),
      .div_o  (div_c[g+1]),
      .num_o  (num_c[g+1]),
      .quo_o  (quo_c[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_c[CELLS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_q.out_value <= quo_c[CELLS];
      out_word_q.out_last  <= ctl_c[CELLS].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `MMN_ASSERT(a_div_below_scale, ctl_c[CELLS].valid && !ctl_c[CELLS].bypass,
    quo_c[CELLS] != mmn_pkg::OUT_SCALE, "division result reached full scale")
  `MMN_ASSERT(a_range_fits, 1'b1,
    ({1'b0, held_min} + {1'b0, held_range}) <= {1'b0, {PIXEL_BITS{1'b1}}},
    "latched min plus range overflows")
  `MMN_ASSERT_NEXT(a_conv_enters, conv, ctl_c[0].valid,
    "accepted convert word missing from prepare stage")
  `MMN_ASSERT(a_out_from_chain, $rose(out_valid_q), $past(ctl_c[CELLS].valid),
    "output word without a word in the last cell")

endmodule

// ----- test/min_max_normalize_to_u8_tb.sv -----
// Self-checking testbench for the two-pass min-max stretch to 8-bit pixels.
`timescale 1ns / 1ps
module min_max_normalize_to_u8_tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned TAIL_CYCLES = 30;
  localparam int unsigned ITEM_COUNT  = 1800;

  typedef struct {
    mmn_pkg::in_word_t word;
    bit                drain;
  } feed_entry_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  mmn_pkg::in_word_t  in_word_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  mmn_pkg::out_word_t out_word_o;

  feed_entry_t        feed_q[$];
  mmn_pkg::out_word_t stretched_q[$];

  logic [mmn_pkg::IN_PIX_BITS-1:0] lo_seen = '1;
  logic [mmn_pkg::IN_PIX_BITS-1:0] hi_seen = '0;
  logic [mmn_pkg::IN_PIX_BITS-1:0] base_px = '0;
  logic [mmn_pkg::IN_PIX_BITS-1:0] span_px = '0;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left    = 0;
  int unsigned hold_left   = 0;
  int unsigned calm_left   = 0;
  int unsigned steady_left = 0;

  min_max_normalize_to_u8 #(
    .PIXEL_BITS(16)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic [mmn_pkg::QUO_BITS-1:0] scale_pixel(
    logic [mmn_pkg::IN_PIX_BITS-1:0] px
  );
    logic [mmn_pkg::IN_PIX_BITS-1:0] diff;
    logic [31:0]                     quo;
    if (span_px == '0) return px[mmn_pkg::QUO_BITS-1:0];
    if (px < base_px) return mmn_pkg::OUT_ZERO;
    diff = px - base_px;
    if (diff >= span_px) return mmn_pkg::OUT_SCALE;
    quo = (32'(mmn_pkg::OUT_SCALE) * 32'(diff)) / 32'(span_px);
    if (quo > 32'(mmn_pkg::OUT_SCALE)) return mmn_pkg::OUT_SCALE;
    return quo[mmn_pkg::QUO_BITS-1:0];
  endfunction

  function automatic void track_and_scale(mmn_pkg::in_word_t w);
    logic [mmn_pkg::IN_PIX_BITS-1:0] mn;
    logic [mmn_pkg::IN_PIX_BITS-1:0] mx;
    mmn_pkg::out_word_t              res;
    if (w.op == mmn_pkg::OP_MEASURE) begin
      mn = (w.pixel < lo_seen) ? w.pixel : lo_seen;
      mx = (w.pixel > hi_seen) ? w.pixel : hi_seen;
      if (w.last) begin
        base_px = mn;
        span_px = (mx >= mn) ? (mx - mn) : '0;
        lo_seen = '1;
        hi_seen = '0;
      end else begin
        lo_seen = mn;
        hi_seen = mx;
      end
    end else begin
      res.out_value = scale_pixel(w.pixel);
      res.out_last  = w.last;
      stretched_q.insert(stretched_q.size(), res);
    end
  endfunction

  function automatic int unsigned next_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_left = $urandom_range(30, 150);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned next_hold();
    int unsigned r;
    if (steady_left != 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) steady_left = $urandom_range(30, 150);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_word(logic op, logic [mmn_pkg::IN_PIX_BITS-1:0] px, logic lst,
                            bit drain);
    feed_entry_t e;
    e.word.op    = op;
    e.word.pixel = px;
    e.word.last  = lst;
    e.drain      = drain;
    feed_q.insert(feed_q.size(), e);
  endtask

  function automatic logic [mmn_pkg::IN_PIX_BITS-1:0] clamp_px(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[mmn_pkg::IN_PIX_BITS-1:0];
  endfunction

  task automatic queue_image();
    int unsigned kind;
    int unsigned n_meas;
    int unsigned n_conv;
    int          lo;
    int          hi;
    int unsigned r;
    logic [mmn_pkg::IN_PIX_BITS-1:0] px;
    kind   = $urandom_range(0, 9);
    n_meas = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
    n_conv = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
    lo = $urandom_range(0, 65535);
    case ($urandom_range(0, 3))
      0: hi = lo;
      1: hi = lo + $urandom_range(1, 15);
      2: hi = lo + $urandom_range(16, 4000);
      default: begin
        lo = $urandom_range(0, 200);
        hi = 65535 - $urandom_range(0, 200);
      end
    endcase
    if (hi > 65535) hi = 65535;
    if (kind < 8) begin
      for (int unsigned i = 0; i < n_meas; i++) begin
        px = clamp_px(lo + $urandom_range(0, hi - lo));
        queue_word(mmn_pkg::OP_MEASURE, px, i == n_meas - 1, 1'b0);
      end
      for (int unsigned j = 0; j < n_conv; j++) begin
        r = $urandom_range(0, 99);
        if (r < 70) px = clamp_px(lo + $urandom_range(0, hi - lo));
        else if (r < 78) px = clamp_px(lo - int'($urandom_range(1, 50)));
        else if (r < 86) px = clamp_px(hi + int'($urandom_range(1, 50)));
        else px = 16'($urandom_range(0, 65535));
        queue_word(mmn_pkg::OP_CONVERT, px, j == n_conv - 1,
                   (j == 0) && ($urandom_range(0, 15) == 0));
      end
    end else begin
      for (int unsigned i = 0; i < n_meas + n_conv; i++) begin
        queue_word(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                   $urandom_range(0, 5) == 0, 1'b0);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit took;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      gap_left   <= 0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) track_and_scale(in_word_i);
      if (!in_valid_i || took) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (feed_q.size() != 0 &&
                     !(feed_q[0].drain && stretched_q.size() != 0)) begin
          in_word_i  <= feed_q[0].word;
          in_valid_i <= 1'b1;
          gap_left   <= next_gap();
          void'(feed_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    mmn_pkg::out_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (stretched_q.size() == 0) begin
          report_mismatch("unexpected result, out_value", 32'(out_word_o.out_value), 0);
        end else begin
          want = stretched_q.pop_front();
          if (out_word_o.out_value !== want.out_value)
            report_mismatch("out_value", 32'(out_word_o.out_value), 32'(want.out_value));
          if (out_word_o.out_last !== want.out_last)
            report_mismatch("out_last", 32'(out_word_o.out_last), 32'(want.out_last));
        end
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        hold_left   <= next_hold();
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("min_max_normalize_to_u8_tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned waited;
    // convert with reset latches: range zero passes the low byte
    queue_word(mmn_pkg::OP_CONVERT, 16'h1234, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'hFFFF, 1'b1, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'h0000, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_MEASURE, 16'd600, 1'b0, 1'b1);
    queue_word(mmn_pkg::OP_MEASURE, 16'd100, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_MEASURE, 16'd1100, 1'b1, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'd100, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'd1100, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'd99, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'd1101, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'd600, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'h0000, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'hFFFF, 1'b1, 1'b0);
    queue_word(mmn_pkg::OP_MEASURE, 16'h5A5A, 1'b1, 1'b1);
    queue_word(mmn_pkg::OP_CONVERT, 16'hABCD, 1'b1, 1'b0);
    queue_word(mmn_pkg::OP_MEASURE, 16'hFFFF, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_MEASURE, 16'h0000, 1'b1, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'hFFFE, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'h0000, 1'b0, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'h8000, 1'b1, 1'b0);
    queue_word(mmn_pkg::OP_CONVERT, 16'hFFFF, 1'b0, 1'b1);
    while (feed_q.size() < ITEM_COUNT) queue_image();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() != 0 || in_valid_i) @(posedge clk_i);
    waited = 0;
    while (stretched_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (stretched_q.size() != 0)
      report_mismatch("results never arrived", 32'(stretched_q.size()), 0);

    if (error_count == 0) begin
      $display("min_max_normalize_to_u8_tb: done, clean");
    end else begin
      $display("min_max_normalize_to_u8_tb: done, errors");
    end
    $finish;
  end

endmodule
